/* rtl/crng_pkg.sv */
// crng_pkg: constants and helpers of the combined lcg shuffle generator
// used by crng_mulmod and combined_lcg_shuffle_rng_top, no dependencies
`default_nettype none

package crng_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned WARMUP      = TABLE_DEPTH + 8;
  localparam int unsigned CNT_W       = $clog2(WARMUP);

  localparam int unsigned GEN_W  = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = GEN_W + MUL_W;
  localparam int unsigned FOLD_W = 8;

  localparam logic [GEN_W-1:0]  MOD_A = 31'd2147483563;
  localparam logic [GEN_W-1:0]  MOD_B = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_B = 16'd40692;
  // 2^31 minus modulus, used to fold the high product bits
  localparam logic [FOLD_W-1:0] FOLD_A = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_B = 8'd249;

  localparam logic [GEN_W-1:0] GEN_TWO_INIT = 31'd123456789;
  localparam longint           SPAN         = 64'd2147483562;
  localparam longint           SLOT_WIDTH   = 1 + SPAN / TABLE_DEPTH;

  function automatic logic [IDX_W-1:0] slot_of(logic [GEN_W-1:0] v);
    logic [IDX_W-1:0] s;
    s = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, v} >= 32'(longint'(k) * SLOT_WIDTH)) begin
        s = IDX_W'(k);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/crng_mulmod.sv */
// crng_mulmod: two-stage (mul * x) mod m for either generator
// depends on crng_pkg
`default_nettype none

module crng_mulmod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        issue_i,
  input  wire logic                        sel_b_i,
  input  wire logic [crng_pkg::GEN_W-1:0]  x_i,
  output logic      [crng_pkg::GEN_W-1:0]  res_o
);

  logic [crng_pkg::MUL_W-1:0]  mul;
  logic [crng_pkg::PROD_W-1:0] prod;
  logic [crng_pkg::PROD_W-1:0] prod_q;
  logic                        sel_q;
  logic                        v1_q;
  logic [crng_pkg::FOLD_W-1:0] fold;
  logic [crng_pkg::GEN_W-1:0]  modv;
  logic [23:0]                 hi_fold;
  logic [31:0]                 sum;
  logic [31:0]                 red;
  logic [crng_pkg::GEN_W-1:0]  res_q;

  always_comb begin
    mul  = sel_b_i ? crng_pkg::MUL_B : crng_pkg::MUL_A;
    prod = crng_pkg::PROD_W'(x_i) * crng_pkg::PROD_W'(mul);
  end

  // high part times (2^31 - m) plus low part stays below 2m
  always_comb begin
    fold    = sel_q ? crng_pkg::FOLD_B : crng_pkg::FOLD_A;
    modv    = sel_q ? crng_pkg::MOD_B : crng_pkg::MOD_A;
    hi_fold = 24'(prod_q[crng_pkg::PROD_W-1:crng_pkg::GEN_W]) * 24'(fold);
    sum     = 32'(prod_q[crng_pkg::GEN_W-1:0]) + 32'(hi_fold);
    red     = (sum >= 32'(modv)) ? (sum - 32'(modv)) : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod;
      sel_q  <= sel_b_i;
    end
    if (v1_q) begin
      res_q <= red[crng_pkg::GEN_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* rtl/combined_lcg_shuffle_rng_top.sv */
// combined_lcg_shuffle_rng_top: two combined lcgs with a shuffle table
// depends on crng_pkg and crng_mulmod
//
// input channel: in_valid_i / in_ready_o carry one word of op_i and seed_i.
//   op_i = 0 draws the next deviate, op_i = 1 reseeds from seed_i, then draws.
// output channel: out_valid_o / out_ready_i carry one deviate_o per word,
//   an integer in 1..2147483562; deviate / 2147483563 is uniform in (0,1).
// a draw passes ST_DR_B, ST_DR_A and ST_DR_FIN before out_valid_o rises;
//   words are accepted only in ST_IDLE. the generator steps run through
//   one shared two-stage multiply-modulo unit, the table read overlaps them.
// a reseed runs TABLE_DEPTH + 8 warm-up steps, each through ST_RS_WAIT and
//   ST_RS_DONE, since each step depends on the previous one.
// the shuffle table is a single-port-write memory with a registered read.
// after reset the first generator is zero, so the first word always reseeds
//   (with 1 on a draw) and fills the whole table before it is read.
// a finished word sits in the output register; the next word is accepted
//   meanwhile and its result waits until the register is taken.
`default_nettype none

module combined_lcg_shuffle_rng_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        op_i,
  input  wire logic [crng_pkg::GEN_W-1:0]  seed_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [crng_pkg::GEN_W-1:0]  deviate_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RS_WAIT,
    ST_RS_DONE,
    ST_DR_B,
    ST_DR_A,
    ST_DR_FIN
  } state_e;

  state_e                       state_q;
  logic [crng_pkg::GEN_W-1:0]   gen_one_q;
  logic [crng_pkg::GEN_W-1:0]   gen_two_q;
  logic [crng_pkg::GEN_W-1:0]   last_out_q;
  logic [crng_pkg::CNT_W-1:0]   cnt_q;
  logic [crng_pkg::IDX_W-1:0]   slot_q;
  logic                         out_valid_q;
  logic [crng_pkg::GEN_W-1:0]   deviate_q;

  logic [crng_pkg::GEN_W-1:0]   table_q [crng_pkg::TABLE_DEPTH];
  logic [crng_pkg::GEN_W-1:0]   rdata_q;

  logic                         accept;
  logic                         reseed;
  logic [crng_pkg::GEN_W-1:0]   seed_eff;
  logic                         issue;
  logic                         sel_b;
  logic [crng_pkg::GEN_W-1:0]   step_x;
  logic [crng_pkg::GEN_W-1:0]   step_res;
  logic                         out_free;
  logic                         fin;
  logic [crng_pkg::GEN_W-1:0]   slot_src;
  logic [crng_pkg::IDX_W-1:0]   slot_d;
  logic                         re;
  logic                         we;
  logic [crng_pkg::IDX_W-1:0]   waddr;
  logic [crng_pkg::GEN_W-1:0]   wdata;
  logic [31:0]                  ydiff;
  logic [31:0]                  yfold;
  logic [crng_pkg::GEN_W-1:0]   y;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign reseed     = op_i || (gen_one_q == '0);
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin        = (state_q == ST_DR_FIN) && out_free;

  always_comb begin
    if (op_i) begin
      seed_eff = (seed_i == '0) ? crng_pkg::GEN_W'(1) : seed_i;
    end else begin
      seed_eff = crng_pkg::GEN_W'(1);
    end
  end

  // shared multiply-modulo unit
  always_comb begin
    issue  = 1'b0;
    sel_b  = 1'b0;
    step_x = gen_one_q;
    case (state_q)
      ST_IDLE: begin
        issue  = accept;
        step_x = reseed ? seed_eff : gen_one_q;
      end
      ST_RS_DONE: begin
        issue  = 1'b1;
        step_x = step_res;
      end
      ST_DR_B: begin
        issue  = 1'b1;
        sel_b  = 1'b1;
        step_x = gen_two_q;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  crng_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .sel_b_i (sel_b),
    .x_i     (step_x),
    .res_o   (step_res)
  );

  // table access
  always_comb begin
    slot_src = (state_q == ST_RS_DONE) ? step_res : last_out_q;
    slot_d   = crng_pkg::slot_of(slot_src);
    re       = (accept && !reseed) || ((state_q == ST_RS_DONE) && (cnt_q == '0));
    we       = 1'b0;
    waddr    = slot_q;
    wdata    = gen_one_q;
    if (state_q == ST_RS_DONE) begin
      we    = (cnt_q < crng_pkg::CNT_W'(crng_pkg::TABLE_DEPTH));
      waddr = cnt_q[crng_pkg::IDX_W-1:0];
      wdata = step_res;
    end else if (fin) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= (we && (waddr == slot_d)) ? wdata : table_q[slot_d];
    end
  end

  // combine and fold into 1..span
  always_comb begin
    ydiff = {1'b0, rdata_q} - {1'b0, step_res};
    yfold = ydiff + 32'(crng_pkg::SPAN);
    if (ydiff[31] || (ydiff == '0)) begin
      y = yfold[crng_pkg::GEN_W-1:0];
    end else begin
      y = ydiff[crng_pkg::GEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_one_q   <= '0;
      gen_two_q   <= crng_pkg::GEN_TWO_INIT;
      last_out_q  <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      deviate_q   <= '0;
    end else begin
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (reseed) begin
              gen_two_q <= seed_eff;
              cnt_q     <= crng_pkg::CNT_W'(crng_pkg::WARMUP - 1);
              state_q   <= ST_RS_WAIT;
            end else begin
              slot_q  <= slot_d;
              state_q <= ST_DR_B;
            end
          end
        end
        ST_RS_WAIT: begin
          state_q <= ST_RS_DONE;
        end
        ST_RS_DONE: begin
          gen_one_q <= step_res;
          if (cnt_q == '0) begin
            last_out_q <= step_res;
            slot_q     <= slot_d;
            state_q    <= ST_DR_B;
          end else begin
            cnt_q   <= cnt_q - crng_pkg::CNT_W'(1);
            state_q <= ST_RS_WAIT;
          end
        end
        ST_DR_B: begin
          state_q <= ST_DR_A;
        end
        ST_DR_A: begin
          gen_one_q <= step_res;
          state_q   <= ST_DR_FIN;
        end
        ST_DR_FIN: begin
          if (out_free) begin
            gen_two_q  <= step_res;
            last_out_q <= y;
            deviate_q  <= y;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign deviate_o   = deviate_q;

endmodule

`default_nettype wire
